@@ design/rsag_pkg.sv @@
// Package for the RMS sound activity gate: payload structs, config
// register codes, widths and the frame record passed front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rsag_pkg;

    localparam int MAX_FRAME_SAMPLES = 1024;
    localparam int CNT_W             = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int SAMPLE_W          = 16;
    localparam int ENERGY_W          = 41;
    localparam int THRESH_W          = 31;
    localparam int TIME_W            = 32;
    localparam int PROD_W            = THRESH_W + CNT_W;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 32;

    // frame record queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [THRESH_W-1:0] OPEN_ENERGY_RST  = THRESH_W'(107374);
    localparam logic [THRESH_W-1:0] CLOSE_ENERGY_RST = THRESH_W'(33955);
    localparam logic [TIME_W-1:0]   HANGOVER_MS_RST  = TIME_W'(10000);

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_ENERGY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_ENERGY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HANGOVER_MS  = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_last;
        logic [TIME_W-1:0]          time_ms;
        logic                       inhibit;
    } t_in_item;

    typedef struct packed {
        logic                gate_active;
        logic                gate_opened;
        logic                gate_closed;
        logic [ENERGY_W-1:0] frame_energy;
    } t_out_item;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [CNT_W-1:0]    count;
        logic [TIME_W-1:0]   time_ms;
        logic                inhibit;
    } t_frame_rec;

    typedef struct packed {
        logic [THRESH_W-1:0] open_energy;
        logic [THRESH_W-1:0] close_energy;
        logic [TIME_W-1:0]   hangover_ms;
    } t_cfg;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

@@ design/rsag_front.sv @@
// Front end: squares each sample and accumulates frame energy and count,
// up to MAX_FRAME_SAMPLES samples; on the last sample of a frame it emits a frame record. Uses rsag_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsag_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire rsag_pkg::t_in_item  i_in_item,
    input  wire rsag_pkg::t_q_status i_q_status,
    output logic                     o_push,
    output rsag_pkg::t_frame_rec     o_rec
);

    logic [rsag_pkg::ENERGY_W-1:0] r_sum, n_sum;
    logic [rsag_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [rsag_pkg::SAMPLE_W:0]   mag;
    logic [2*rsag_pkg::SAMPLE_W+1:0] sq;
    logic [rsag_pkg::ENERGY_W:0]   sum_wide;
    logic                          accept;
    logic                          take;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign take       = r_cnt < rsag_pkg::CNT_W'(rsag_pkg::MAX_FRAME_SAMPLES);

    always_comb begin
        mag = i_in_item.sample[rsag_pkg::SAMPLE_W-1]
            ? ((rsag_pkg::SAMPLE_W+1)'(0) - {i_in_item.sample[rsag_pkg::SAMPLE_W-1],
                                             i_in_item.sample})
            : {1'b0, i_in_item.sample};
        sq       = mag * mag;
        sum_wide = {1'b0, r_sum}
                 + (rsag_pkg::ENERGY_W+1)'(sq);
        if (!take) begin
            n_sum = r_sum;
            n_cnt = r_cnt;
        end else begin
            // saturate at all ones
            n_sum = sum_wide[rsag_pkg::ENERGY_W] ? '1 : sum_wide[rsag_pkg::ENERGY_W-1:0];
            n_cnt = r_cnt + rsag_pkg::CNT_W'(1);
        end
    end

    assign o_push        = accept && i_in_item.frame_last;
    assign o_rec.energy  = n_sum;
    assign o_rec.count   = n_cnt;
    assign o_rec.time_ms = i_in_item.time_ms;
    assign o_rec.inhibit = i_in_item.inhibit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            if (i_in_item.frame_last) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
        end
    end

endmodule
`default_nettype wire

@@ design/rsag_queue.sv @@
// Short queue of frame records between front and back end.
// Register based, read at the head pointer. Uses rsag_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsag_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rsag_pkg::t_q_ctrl    i_ctrl,
    input  wire rsag_pkg::t_frame_rec i_wr_rec,
    output rsag_pkg::t_frame_rec      o_rd_rec,
    output rsag_pkg::t_q_status       o_status
);

    rsag_pkg::t_frame_rec r_mem [rsag_pkg::QDEPTH];
    logic [rsag_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [rsag_pkg::QCNT_W-1:0] r_count;
    logic                        do_push, do_pop;

    assign o_status.full  = r_count == rsag_pkg::QCNT_W'(rsag_pkg::QDEPTH);
    assign o_status.empty = r_count == '0;
    assign do_push        = i_ctrl.push && !o_status.full;
    assign do_pop         = i_ctrl.pop && !o_status.empty;
    assign o_rd_rec       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + rsag_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + rsag_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + rsag_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - rsag_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_rec;
        end
    end

endmodule
`default_nettype wire

@@ design/rsag_back.sv @@
// Back end: threshold products, hysteresis/hangover decision and the
// output register. Uses rsag_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsag_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rsag_pkg::t_cfg       i_cfg,
    input  wire rsag_pkg::t_frame_rec i_rec,
    input  wire rsag_pkg::t_q_status  i_q_status,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output rsag_pkg::t_out_item       o_out_item
);

    localparam int PAD_W = rsag_pkg::PROD_W - rsag_pkg::ENERGY_W;

    logic                        adv;
    logic                        r_b1_valid;
    rsag_pkg::t_frame_rec        r_b1_rec;
    logic [rsag_pkg::PROD_W-1:0] r_open_prod, r_close_prod;
    logic [rsag_pkg::PROD_W-1:0] energy_ext;

    logic                        r_active, n_active;
    logic                        r_timing, n_timing;
    logic [rsag_pkg::TIME_W-1:0] r_start, n_start;
    logic [rsag_pkg::TIME_W-1:0] elapsed;

    logic                        r_out_valid;
    rsag_pkg::t_out_item         r_out_item;

    // whole back pipeline moves together when the output slot frees up
    assign adv   = !r_out_valid || !i_out_stall;
    assign o_pop = adv && !i_q_status.empty;

    assign energy_ext = {{PAD_W{1'b0}}, r_b1_rec.energy};
    assign elapsed    = r_b1_rec.time_ms - r_start;

    always_comb begin
        n_active = r_active;
        n_timing = r_timing;
        n_start  = r_start;
        if (r_active) begin
            if (energy_ext > r_close_prod) begin
                n_timing = 1'b0;
            end else if (!r_timing) begin
                // first quiet frame only arms the timer
                n_timing = 1'b1;
                n_start  = r_b1_rec.time_ms;
            end else if (elapsed >= i_cfg.hangover_ms) begin
                n_active = 1'b0;
                n_timing = 1'b0;
            end
        end else if (energy_ext > r_open_prod) begin
            n_active = 1'b1;
            n_timing = 1'b0;
        end
        if (r_b1_rec.inhibit) begin
            n_active = 1'b0;
            n_timing = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_timing    <= 1'b0;
            r_start     <= '0;
        end else if (adv) begin
            r_b1_valid  <= !i_q_status.empty;
            r_out_valid <= r_b1_valid;
            if (r_b1_valid) begin
                r_active <= n_active;
                r_timing <= n_timing;
                r_start  <= n_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1_rec     <= i_rec;
            r_open_prod  <= {{rsag_pkg::CNT_W{1'b0}}, i_cfg.open_energy}
                          * {{rsag_pkg::THRESH_W{1'b0}}, i_rec.count};
            r_close_prod <= {{rsag_pkg::CNT_W{1'b0}}, i_cfg.close_energy}
                          * {{rsag_pkg::THRESH_W{1'b0}}, i_rec.count};
            r_out_item.gate_active  <= n_active;
            r_out_item.gate_opened  <= !r_active && n_active;
            r_out_item.gate_closed  <= r_active && !n_active;
            r_out_item.frame_energy <= r_b1_rec.energy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

@@ design/rms_sound_activity_gate.sv @@
// RMS sound activity gate, top level: config registers, front end,
// frame record queue and back end. Uses rsag_pkg and the rsag_* modules.
// Throughput: one sample per cycle; upstream stalls only when 4 frame
//   records wait in the queue behind a stalled output.
// Path: a frame-last sample's result is registered through the queue, the
//   product stage and the decision/output register; an output stall can hold it.
// Reset (sync, active low): clears sums, queue, gate state and valids;
//   config registers return to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module rms_sound_activity_gate (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire rsag_pkg::t_in_item                i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output rsag_pkg::t_out_item                    o_out_item,
    input  wire logic                              i_cfg_we,
    input  wire logic [rsag_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rsag_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    rsag_pkg::t_cfg       r_cfg;
    rsag_pkg::t_q_ctrl    q_ctrl;
    rsag_pkg::t_q_status  q_status;
    rsag_pkg::t_frame_rec push_rec, head_rec;
    logic                 push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_energy  <= rsag_pkg::OPEN_ENERGY_RST;
            r_cfg.close_energy <= rsag_pkg::CLOSE_ENERGY_RST;
            r_cfg.hangover_ms  <= rsag_pkg::HANGOVER_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rsag_pkg::CFG_OPEN_ENERGY: begin
                    r_cfg.open_energy <= i_cfg_data[rsag_pkg::THRESH_W-1:0];
                end
                rsag_pkg::CFG_CLOSE_ENERGY: begin
                    r_cfg.close_energy <= i_cfg_data[rsag_pkg::THRESH_W-1:0];
                end
                rsag_pkg::CFG_HANGOVER_MS: begin
                    r_cfg.hangover_ms <= i_cfg_data[rsag_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    rsag_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_status (q_status),
        .o_push     (push),
        .o_rec      (push_rec)
    );

    rsag_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (q_ctrl),
        .i_wr_rec (push_rec),
        .o_rd_rec (head_rec),
        .o_status (q_status)
    );

    rsag_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rec       (head_rec),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // a frame record is never offered to a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("frame record pushed into full queue");

    a_open_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.gate_opened |-> o_out_item.gate_active)
        else $error("open edge without active gate");

    a_close_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.gate_closed |-> !o_out_item.gate_active)
        else $error("close edge with active gate");

    // a result leaves only after a request went through the queue
    a_out_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(pop, 2))
        else $error("result without queued frame");

endmodule
`default_nettype wire
